### src/vag_pkg.sv
// Shared types, constants and tap tables for the block ADPCM decoder.
package vag_pkg;

   // Fixed sizes of the stream format
   localparam int FRACTION_BITS_DEF = 10;
   localparam int HIST_W            = 32;
   localparam int TAP_W             = 8;
   localparam int PRED_SHIFT        = 6;
   localparam int NUM_FILTERS       = 5;

   // Block positions with a special meaning
   localparam logic [3:0] POS_HEADER = 4'd0;
   localparam logic [3:0] POS_FLAGS  = 4'd1;

   // Input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_stream;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_of_pair;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic mul;
      logic acc;
      logic load_out;
      logic sel_hi;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic data_byte;
   } stat_type;

   // Tap applied to the newest history value, in 64ths
   function automatic logic signed [TAP_W-1:0] tap_recent(input logic [2:0] filt);
      logic signed [TAP_W-1:0] k;
      case (filt)
         3'd1:    k = 8'sd60;
         3'd2:    k = 8'sd115;
         3'd3:    k = 8'sd98;
         3'd4:    k = 8'sd122;
         default: k = 8'sd0;
      endcase
      return k;
   endfunction

   // Tap applied to the older history value, in 64ths
   function automatic logic signed [TAP_W-1:0] tap_older(input logic [2:0] filt);
      logic signed [TAP_W-1:0] k;
      case (filt)
         3'd2:    k = -8'sd52;
         3'd3:    k = -8'sd55;
         3'd4:    k = -8'sd60;
         default: k = 8'sd0;
      endcase
      return k;
   endfunction

endpackage

### src/vag_adpcm_block_decoder.sv
// Top level of the 16-byte-block 4-bit ADPCM decoder.
//
//   channel  direction  handshake           beat
//   req_     in         req_valid/req_stall req_payload (in_byte, new_stream)
//   rsp_     out        rsp_valid/rsp_stall rsp_payload (sample, last_of_pair)
//
// Header and flag bytes give no result.
// A data byte passes through intake, then multiply, accumulate and output load
// for each nibble; the history dependency through the two-tap multiply-accumulate
// keeps these steps in order. Output load waits while the output register holds a stalled result.
// Reset is synchronous; it clears history, block position, header state and valid.
// A result waits in the output register while the next nibble is computed.
module vag_adpcm_block_decoder #(
   parameter int FRACTION_BITS = vag_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vag_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vag_pkg::rsp_type rsp_payload
);

   vag_pkg::cmd_type  cmd;
   vag_pkg::stat_type stat;

   // Sequencer
   vag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic and block state
   vag_dp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

### src/vag_ctrl.sv
// Controller state machine: input handshake, nibble sequencing, output register valid.
module vag_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  vag_pkg::stat_type  stat,
   output vag_pkg::cmd_type   cmd
);

   vag_pkg::state_type state_ff, state_in;
   logic               hi_ff, hi_in;
   logic               out_valid_ff, out_valid_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vag_pkg::ST_IDLE;
         hi_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hi_ff        <= hi_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      hi_in      = hi_ff;
      req_stall  = 1'b1;
      cmd        = '0;
      cmd.sel_hi = hi_ff;
      case (state_ff)
         vag_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.data_byte) begin
                  state_in = vag_pkg::ST_MUL;
                  hi_in    = 1'b0;
               end
            end
         end
         vag_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = vag_pkg::ST_ACC;
         end
         vag_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = vag_pkg::ST_EMIT;
         end
         vag_pkg::ST_EMIT: begin
            // wait until the output register is free or being drained
            if (!out_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               if (hi_ff) begin
                  state_in = vag_pkg::ST_IDLE;
               end else begin
                  hi_in    = 1'b1;
                  state_in = vag_pkg::ST_MUL;
               end
            end
         end
         default: begin
            state_in = vag_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register occupancy
   assign out_valid_in = cmd.load_out | (out_valid_ff & rsp_stall);
   assign rsp_valid    = out_valid_ff;

`ifndef ASSERT_OFF
   // Input is only taken while no byte is in flight
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != vag_pkg::ST_IDLE) |-> req_stall)
      else $error("input taken while a byte is in flight");

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(out_valid_ff && rsp_stall))
      else $error("output register overwritten");

   // Accumulate always follows a multiply
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vag_pkg::ST_ACC) |-> ($past(state_ff) == vag_pkg::ST_MUL))
      else $error("accumulate without multiply");

   // A data byte starts with its low nibble
   a_data_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && stat.data_byte) |=> (state_ff == vag_pkg::ST_MUL && !hi_ff))
      else $error("data byte did not start on low nibble");
`endif

endmodule

### src/vag_dp.sv
// Datapath: block header state, history, two-tap prediction, rounding and clamp.
module vag_dp #(
   parameter int FRACTION_BITS = vag_pkg::FRACTION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  vag_pkg::req_type  req_payload,
   input  vag_pkg::cmd_type  cmd,
   output vag_pkg::stat_type stat,
   output vag_pkg::rsp_type  rsp_payload
);

   localparam int HW = vag_pkg::HIST_W;
   localparam int PW = HW + vag_pkg::TAP_W;   // one product
   localparam int SW = PW + 1;                // sum of two products
   localparam int FW = SW + 1;                // prediction plus scaled nibble
   localparam int RW = HW + 1;                // rounding word

   logic [3:0]               pos_ff, pos_in, pos_eff;
   logic [2:0]               filter_ff, filter_in;
   logic [3:0]               shift_ff, shift_in;
   logic [7:0]               byte_ff, byte_in;
   logic signed [HW-1:0]     rec_ff, rec_in, old_ff, old_in;
   logic signed [PW-1:0]     prod0_ff, prod0_in, prod1_ff, prod1_in;
   logic signed [15:0]       raw_ff, raw_in;
   vag_pkg::rsp_type         out_ff, out_in;

   logic [3:0]               nib;
   logic signed [15:0]       word;
   logic signed [SW-1:0]     sum, pred;
   logic signed [FW-1:0]     fresh;
   logic signed [HW-1:0]     fresh_sat;
   logic signed [RW-1:0]     t_word, t_adj, q_word;
   logic signed [15:0]       sample_clamp;

   // Effective position after an optional stream restart
   assign pos_eff        = req_payload.new_stream ? vag_pkg::POS_HEADER : pos_ff;
   assign stat.data_byte = (pos_eff != vag_pkg::POS_HEADER) && (pos_eff != vag_pkg::POS_FLAGS);

   // Control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= vag_pkg::POS_HEADER;
         filter_ff <= '0;
         shift_ff  <= '0;
         rec_ff    <= '0;
         old_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         filter_ff <= filter_in;
         shift_ff  <= shift_in;
         rec_ff    <= rec_in;
         old_ff    <= old_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      raw_ff   <= raw_in;
      out_ff   <= out_in;
   end

   // Byte intake and header decode
   always_comb begin
      pos_in    = pos_ff;
      filter_in = filter_ff;
      shift_in  = shift_ff;
      byte_in   = byte_ff;
      if (cmd.accept) begin
         pos_in  = pos_eff + 4'd1;
         byte_in = req_payload.in_byte;
         if (pos_eff == vag_pkg::POS_HEADER) begin
            // out-of-table filter numbers fall back to filter 0
            filter_in = (req_payload.in_byte[7:4] < 4'(vag_pkg::NUM_FILTERS)) ?
                        req_payload.in_byte[6:4] : 3'd0;
            shift_in  = req_payload.in_byte[3:0];
         end
      end
   end

   // Multiply stage: nibble scaling and both tap products
   assign nib      = cmd.sel_hi ? byte_ff[7:4] : byte_ff[3:0];
   assign word     = signed'({nib, 12'h000});
   assign raw_in   = cmd.mul ? (word >>> shift_ff) : raw_ff;
   assign prod0_in = cmd.mul ? (PW'(rec_ff) * PW'(vag_pkg::tap_recent(filter_ff))) : prod0_ff;
   assign prod1_in = cmd.mul ? (PW'(old_ff) * PW'(vag_pkg::tap_older(filter_ff)))  : prod1_ff;

   // Accumulate stage: prediction, new history, saturation
   assign sum   = SW'(prod0_ff) + SW'(prod1_ff);
   assign pred  = sum >>> vag_pkg::PRED_SHIFT;
   assign fresh = FW'(pred) + (FW'(raw_ff) <<< FRACTION_BITS);

   always_comb begin
      if ((&fresh[FW-1:HW-1]) || !(|fresh[FW-1:HW-1])) begin
         fresh_sat = fresh[HW-1:0];
      end else if (fresh[FW-1]) begin
         fresh_sat = {1'b1, {(HW-1){1'b0}}};
      end else begin
         fresh_sat = {1'b0, {(HW-1){1'b1}}};
      end
   end

   // History update
   always_comb begin
      rec_in = rec_ff;
      old_in = old_ff;
      if (cmd.accept && req_payload.new_stream) begin
         rec_in = '0;
         old_in = '0;
      end else if (cmd.acc) begin
         old_in = rec_ff;
         rec_in = fresh_sat;
      end
   end

   // Output: round half up, truncate toward zero, clamp to 16 bits
   assign t_word = RW'(rec_ff) + (RW'(1) <<< (FRACTION_BITS - 1));
   assign t_adj  = t_word[RW-1] ? (t_word + ((RW'(1) <<< FRACTION_BITS) - RW'(1))) : t_word;
   assign q_word = t_adj >>> FRACTION_BITS;

   always_comb begin
      if ((&q_word[RW-1:15]) || !(|q_word[RW-1:15])) begin
         sample_clamp = q_word[15:0];
      end else if (q_word[RW-1]) begin
         sample_clamp = 16'sh8000;
      end else begin
         sample_clamp = 16'sh7fff;
      end
   end

   always_comb begin
      out_in = out_ff;
      if (cmd.load_out) begin
         out_in.sample       = sample_clamp;
         out_in.last_of_pair = cmd.sel_hi;
      end
   end

   assign rsp_payload = out_ff;

endmodule
